// ----- hdl/gaussian_splat_to_rectangle_core_assert.svh -----
// assertion macros shared by the splat pipeline
`ifndef GAUSSIAN_SPLAT_TO_RECTANGLE_CORE_ASSERT_SVH
`define GAUSSIAN_SPLAT_TO_RECTANGLE_CORE_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define GSR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// plain invariant checked on every rising clock edge outside reset
`define GSR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

// ----- hdl/gsr_pkg.sv -----
package gsr_pkg;

  localparam int EXP_TERMS  = 48;
  localparam int QBITS_EXP  = 18;
  localparam int QBITS_ROT  = 15;
  localparam int RATIO_LAT  = QBITS_ROT + 1;
  localparam int EXP_LAT    = 1 + 3 * (EXP_TERMS - 1) + 1 + QBITS_EXP;
  localparam int PIPE_LAT   = 3 + EXP_LAT + 1;

  localparam logic signed [15:0] ONE_Q14     = 16'sd16384;
  localparam logic signed [17:0] COLOUR_BIAS = 18'sd2048;
  localparam logic signed [17:0] COLOUR_MAX  = 18'sd4096;
  localparam logic [31:0]        TWO_Q16     = 32'd131072;

  typedef logic [1:0] axis_t;
  localparam axis_t AXIS_A = 2'd0;
  localparam axis_t AXIS_B = 2'd1;
  localparam axis_t AXIS_C = 2'd2;

  typedef struct packed {
    logic signed [15:0] log_scale_a;
    logic signed [15:0] log_scale_b;
    logic signed [15:0] log_scale_c;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_i;
    logic signed [15:0] quat_j;
    logic signed [15:0] quat_k;
    logic signed [15:0] dc_red;
    logic signed [15:0] dc_green;
    logic signed [15:0] dc_blue;
  } gsr_in_t;

  typedef struct packed {
    logic signed [15:0] major_axis_x;
    logic signed [15:0] major_axis_y;
    logic signed [15:0] major_axis_z;
    logic signed [15:0] minor_axis_x;
    logic signed [15:0] minor_axis_y;
    logic signed [15:0] minor_axis_z;
    logic [31:0]        rect_width;
    logic [31:0]        rect_height;
    logic [31:0]        rect_radius;
    logic [12:0]        red_out;
    logic [12:0]        green_out;
    logic [12:0]        blue_out;
  } gsr_out_t;

  // front end result: selected matrix numerators, norm and side data
  typedef struct packed {
    logic               vld;
    logic [2:0][34:0]   num_maj;
    logic [2:0][34:0]   num_min;
    logic [32:0]        n2;
    logic               n2zero;
    logic signed [15:0] scale_maj;
    logic signed [15:0] scale_min;
    axis_t              first;
    axis_t              second;
    logic [12:0]        red;
    logic [12:0]        green;
    logic [12:0]        blue;
  } gsr_front_t;

  // floor(v / d) for a small constant d, recip = floor(2^32 / d)
  function automatic logic [27:0] div_small(input logic [27:0] v,
                                            input logic [32:0] recip,
                                            input logic [5:0]  d);
    logic [60:0] p;
    logic [27:0] q0;
    logic [27:0] r;
    p  = 61'(v) * 61'(recip);
    q0 = p[59:32];
    r  = v - 28'(q0 * 28'(d));
    if (r >= 28'(d)) begin
      q0 = q0 + 28'd1;
    end
    return q0;
  endfunction

endpackage

// ----- hdl/gsr_front.sv -----
module gsr_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             vld_in,
  input  gsr_pkg::gsr_in_t splat,
  output gsr_pkg::gsr_front_t fr
);

  typedef struct packed {
    logic signed [31:0] ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;
    gsr_pkg::axis_t     first;
    gsr_pkg::axis_t     second;
    logic signed [15:0] scale_maj;
    logic signed [15:0] scale_min;
    logic [12:0]        red, green, blue;
  } st2_t;

  function automatic logic [12:0] colour(input logic signed [15:0] dc);
    logic signed [17:0] c;
    c = 18'(dc) + gsr_pkg::COLOUR_BIAS;
    if (c < 18'sd0) begin
      c = 18'sd0;
    end else if (c > gsr_pkg::COLOUR_MAX) begin
      c = gsr_pkg::COLOUR_MAX;
    end
    return c[12:0];
  endfunction

  gsr_pkg::gsr_in_t s1;
  logic             v1;
  st2_t             s2, s2_next;
  logic             v2;
  gsr_pkg::gsr_front_t fr_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      fr.vld <= 1'b0;
    end else begin
      v1 <= vld_in;
      v2 <= v1;
      fr.vld <= v2;
    end
    s1 <= splat;
    s2 <= s2_next;
    fr.num_maj   <= fr_next.num_maj;
    fr.num_min   <= fr_next.num_min;
    fr.n2        <= fr_next.n2;
    fr.n2zero    <= fr_next.n2zero;
    fr.scale_maj <= fr_next.scale_maj;
    fr.scale_min <= fr_next.scale_min;
    fr.first     <= fr_next.first;
    fr.second    <= fr_next.second;
    fr.red       <= fr_next.red;
    fr.green     <= fr_next.green;
    fr.blue      <= fr_next.blue;
  end

  // products, ranking, colours
  always_comb begin
    logic signed [15:0] sc [3];
    gsr_pkg::axis_t f, s;
    sc[0] = s1.log_scale_a;
    sc[1] = s1.log_scale_b;
    sc[2] = s1.log_scale_c;
    s2_next.ww = s1.quat_w * s1.quat_w;
    s2_next.xx = s1.quat_i * s1.quat_i;
    s2_next.yy = s1.quat_j * s1.quat_j;
    s2_next.zz = s1.quat_k * s1.quat_k;
    s2_next.xy = s1.quat_i * s1.quat_j;
    s2_next.wz = s1.quat_w * s1.quat_k;
    s2_next.xz = s1.quat_i * s1.quat_k;
    s2_next.wy = s1.quat_w * s1.quat_j;
    s2_next.yz = s1.quat_j * s1.quat_k;
    s2_next.wx = s1.quat_w * s1.quat_i;
    // ties keep the lower index
    f = gsr_pkg::AXIS_A;
    if (sc[1] > sc[0]) begin
      f = gsr_pkg::AXIS_B;
    end
    if (sc[2] > sc[f]) begin
      f = gsr_pkg::AXIS_C;
    end
    unique case (f)
      gsr_pkg::AXIS_A: s = (sc[2] > sc[1]) ? gsr_pkg::AXIS_C : gsr_pkg::AXIS_B;
      gsr_pkg::AXIS_B: s = (sc[2] > sc[0]) ? gsr_pkg::AXIS_C : gsr_pkg::AXIS_A;
      default:         s = (sc[1] > sc[0]) ? gsr_pkg::AXIS_B : gsr_pkg::AXIS_A;
    endcase
    s2_next.first     = f;
    s2_next.second    = s;
    s2_next.scale_maj = sc[f];
    s2_next.scale_min = sc[s];
    s2_next.red   = colour(s1.dc_red);
    s2_next.green = colour(s1.dc_green);
    s2_next.blue  = colour(s1.dc_blue);
  end

  // norm and the two selected matrix columns, scaled by the norm
  always_comb begin
    logic [32:0] n2;
    logic signed [34:0] nn, ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;
    logic signed [34:0] e [3][3];
    ww = 35'(s2.ww);
    xx = 35'(s2.xx);
    yy = 35'(s2.yy);
    zz = 35'(s2.zz);
    xy = 35'(s2.xy);
    wz = 35'(s2.wz);
    xz = 35'(s2.xz);
    wy = 35'(s2.wy);
    yz = 35'(s2.yz);
    wx = 35'(s2.wx);
    n2 = 33'($unsigned(s2.ww)) + 33'($unsigned(s2.xx))
       + 33'($unsigned(s2.yy)) + 33'($unsigned(s2.zz));
    nn = $signed({2'b00, n2});
    e[0][0] = nn - ((yy + zz) <<< 1);
    e[0][1] = (xy - wz) <<< 1;
    e[0][2] = (xz + wy) <<< 1;
    e[1][0] = (xy + wz) <<< 1;
    e[1][1] = nn - ((xx + zz) <<< 1);
    e[1][2] = (yz - wx) <<< 1;
    e[2][0] = (xz - wy) <<< 1;
    e[2][1] = (yz + wx) <<< 1;
    e[2][2] = nn - ((xx + yy) <<< 1);
    fr_next.vld = v2;
    for (int r = 0; r < 3; r++) begin
      fr_next.num_maj[r] = e[r][s2.first];
      fr_next.num_min[r] = e[r][s2.second];
    end
    fr_next.n2        = n2;
    fr_next.n2zero    = (n2 == 33'd0);
    fr_next.scale_maj = s2.scale_maj;
    fr_next.scale_min = s2.scale_min;
    fr_next.first     = s2.first;
    fr_next.second    = s2.second;
    fr_next.red       = s2.red;
    fr_next.green     = s2.green;
    fr_next.blue      = s2.blue;
  end

endmodule

// ----- hdl/gsr_ratio.sv -----
module gsr_ratio (
  input  logic               clk,
  input  logic signed [34:0] num,
  input  logic [32:0]        den,
  output logic signed [15:0] ratio
);

  localparam int QB = gsr_pkg::QBITS_ROT;

  typedef struct packed {
    logic        neg;
    logic [48:0] rem;
    logic [33:0] d;
    logic [QB-1:0] q;
  } dv_t;

  dv_t st [QB+1];

  // round(|num| * 2^14 / den) half up, as floor((|num| << 15 + den) / (2 den))
  always_ff @(posedge clk) begin
    logic [33:0] mag;
    mag = num[34] ? 34'(-num) : 34'(num);
    st[0].neg <= num[34];
    st[0].rem <= {mag, 15'b0} + 49'(den);
    st[0].d   <= {den, 1'b0};
    st[0].q   <= '0;
  end

  for (genvar i = 0; i < QB; i++) begin : g_bit
    localparam int B = QB - 1 - i;
    always_ff @(posedge clk) begin
      logic [48:0] sh;
      dv_t         nx;
      sh = 49'(st[i].d) << B;
      nx = st[i];
      if (st[i].rem >= sh) begin
        nx.rem  = st[i].rem - sh;
        nx.q[B] = 1'b1;
      end
      st[i+1] <= nx;
    end
  end

  assign ratio = st[QB].neg ? -$signed({1'b0, st[QB].q}) : $signed({1'b0, st[QB].q});

endmodule

// ----- hdl/gsr_exp.sv -----
`include "gaussian_splat_to_rectangle_core_assert.svh"

module gsr_exp (
  input  logic             clk,
  input  logic             rst,
  input  logic             vld_in,
  input  logic [1:0][15:0] scale,
  output logic             vld_out,
  output logic [1:0][31:0] size
);

  localparam int NT = gsr_pkg::EXP_TERMS;
  localparam int QB = gsr_pkg::QBITS_EXP;

  typedef struct packed {
    logic        neg;
    logic [15:0] x;
    logic [40:0] term;
    logic [43:0] sum;
  } ser_t;

  typedef struct packed {
    logic        neg;
    logic [28:0] rpos;
    logic [62:0] rem;
    logic [44:0] d;
    logic [QB-1:0] q;
  } dv_t;

  ser_t st [NT][2];
  logic vs [NT];
  dv_t  dv [QB+1][2];
  logic vd [QB+1];
  logic lead_neg;

  // series start: term = sum = 1.0 in Q.32
  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else begin
      vs[0] <= vld_in;
    end
    for (int l = 0; l < 2; l++) begin
      st[0][l].neg  <= scale[l][15];
      st[0][l].x    <= scale[l][15] ? 16'(-$signed(scale[l])) : scale[l];
      st[0][l].term <= 41'h100000000;
      st[0][l].sum  <= 44'h100000000;
    end
  end

  // one series term per three stages: multiply, divide high part, divide low part
  for (genvar g = 1; g < NT; g++) begin : g_term
    localparam logic [32:0] RECIP = 33'(64'h100000000 / g);
    logic [56:0] prod [2];
    ser_t        ca [2];
    ser_t        cb [2];
    logic [22:0] qh [2];
    logic [5:0]  rh [2];
    logic [21:0] al [2];
    logic [22:0] qh_next [2];
    logic [5:0]  rh_next [2];
    ser_t        sc_next [2];
    logic        va, vb;

    always_comb begin
      logic [44:0] a;
      logic [27:0] ah, v;
      logic [21:0] ql;
      logic [40:0] tn;
      for (int l = 0; l < 2; l++) begin
        a  = prod[l][56:12];
        ah = 28'(a[44:22]);
        qh_next[l] = 23'(gsr_pkg::div_small(ah, RECIP, 6'(g)));
        rh_next[l] = 6'(ah - 28'(28'(qh_next[l]) * 28'(g)));
        v  = {rh[l], al[l]};
        ql = 22'(gsr_pkg::div_small(v, RECIP, 6'(g)));
        tn = 41'({qh[l], 22'b0}) + 41'(ql);
        sc_next[l]      = cb[l];
        sc_next[l].term = tn;
        sc_next[l].sum  = cb[l].sum + 44'(tn);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        va    <= 1'b0;
        vb    <= 1'b0;
        vs[g] <= 1'b0;
      end else begin
        va    <= vs[g-1];
        vb    <= va;
        vs[g] <= vb;
      end
      for (int l = 0; l < 2; l++) begin
        prod[l]  <= 57'(st[g-1][l].term) * 57'(st[g-1][l].x);
        ca[l]    <= st[g-1][l];
        qh[l]    <= qh_next[l];
        rh[l]    <= rh_next[l];
        al[l]    <= prod[l][33:12];
        cb[l]    <= ca[l];
        st[g][l] <= sc_next[l];
      end
    end
  end

  // finish: rounding shift for positive scales, reciprocal division otherwise
  always_ff @(posedge clk) begin
    if (rst) begin
      vd[0] <= 1'b0;
    end else begin
      vd[0] <= vs[NT-1];
    end
    for (int l = 0; l < 2; l++) begin
      dv[0][l].neg  <= st[NT-1][l].neg;
      dv[0][l].rpos <= 29'((45'(st[NT-1][l].sum) + 45'h4000) >> 15);
      dv[0][l].rem  <= 63'h4000000000000 + 63'(st[NT-1][l].sum);
      dv[0][l].d    <= {st[NT-1][l].sum, 1'b0};
      dv[0][l].q    <= '0;
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_div
    localparam int B = QB - 1 - i;
    always_ff @(posedge clk) begin
      logic [62:0] sh;
      dv_t         nx;
      if (rst) begin
        vd[i+1] <= 1'b0;
      end else begin
        vd[i+1] <= vd[i];
      end
      for (int l = 0; l < 2; l++) begin
        sh = 63'(dv[i][l].d) << B;
        nx = dv[i][l];
        if (dv[i][l].rem >= sh) begin
          nx.rem  = dv[i][l].rem - sh;
          nx.q[B] = 1'b1;
        end
        dv[i+1][l] <= nx;
      end
    end
  end

  assign vld_out = vd[QB];
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      size[l] = dv[QB][l].neg ? 32'(dv[QB][l].q) : 32'(dv[QB][l].rpos);
    end
  end

  assign lead_neg = dv[QB][0].neg;

  `GSR_ASSERT_IMPL(a_exp_pos_floor, vld_out && !lead_neg, size[0] >= gsr_pkg::TWO_Q16, "size low")
  `GSR_ASSERT_IMPL(a_exp_neg_ceil, vld_out && lead_neg, size[0] <= gsr_pkg::TWO_Q16, "size high")

endmodule

// ----- hdl/gaussian_splat_to_rectangle_core.sv -----
// Gaussian splat to rectangle. Takes one splat per clock (log scales, quaternion,
// colour DC terms) and returns the two dominant axis vectors from the normalized
// rotation matrix, 2*exp of the two largest scales in Q16.16, a radius estimate
// (a quarter of their sum) and clamped colours. Fully pipelined: an item is taken
// in every cycle in which start is high and busy is low; busy is only high during
// reset. Each result shows up on rect with done high for exactly one cycle, in the
// same order as the items were taken. The receiver cannot stall, so nothing here
// waits for it. The depth of the pipeline comes mostly from the exponential series:
// 47 terms at three stages each, followed by an 18-stage reciprocal divider; the
// matrix divisions run in parallel and are delayed to match.

`include "gaussian_splat_to_rectangle_core_assert.svh"

module gaussian_splat_to_rectangle_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  gsr_pkg::gsr_in_t  splat,
  output logic              done,
  output gsr_pkg::gsr_out_t rect
);

  localparam int EL = gsr_pkg::EXP_LAT;
  localparam int RD = gsr_pkg::EXP_LAT - gsr_pkg::RATIO_LAT;

  // side data that rides along with the slow exp path
  typedef struct packed {
    logic           n2zero;
    gsr_pkg::axis_t first;
    gsr_pkg::axis_t second;
    logic [12:0]    red, green, blue;
  } side_t;

  gsr_pkg::gsr_front_t fr;
  logic                ex_vld;
  logic [1:0][31:0]    ex_size;
  logic [5:0][15:0]    rat;
  side_t               side_q [EL];
  logic [5:0][15:0]    rat_q [RD];
  gsr_pkg::gsr_out_t   rect_next;

  // pipeline never holds off: only reset blocks new items
  assign busy = rst;

  gsr_front u_front (
    .clk    (clk),
    .rst    (rst),
    .vld_in (start && !busy),
    .splat  (splat),
    .fr     (fr)
  );

  // six matrix entries: the major and minor columns
  for (genvar e = 0; e < 6; e++) begin : g_ratio
    gsr_ratio u_ratio (
      .clk   (clk),
      .num   ((e < 3) ? fr.num_maj[e % 3] : fr.num_min[e % 3]),
      .den   (fr.n2),
      .ratio (rat[e])
    );
  end

  gsr_exp u_exp (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (fr.vld),
    .scale   ({fr.scale_min, fr.scale_maj}),
    .vld_out (ex_vld),
    .size    (ex_size)
  );

  // delay lines to line up with the exp result
  always_ff @(posedge clk) begin
    side_q[0] <= '{n2zero: fr.n2zero, first: fr.first, second: fr.second,
                   red: fr.red, green: fr.green, blue: fr.blue};
    for (int i = 1; i < EL; i++) begin
      side_q[i] <= side_q[i-1];
    end
    rat_q[0] <= rat;
    for (int i = 1; i < RD; i++) begin
      rat_q[i] <= rat_q[i-1];
    end
  end

  // output assembly
  always_comb begin
    side_t            sd;
    logic [5:0][15:0] rv;
    logic [2:0][15:0] maj, mnr;
    sd = side_q[EL-1];
    rv = rat_q[RD-1];
    for (int r = 0; r < 3; r++) begin
      if (sd.n2zero) begin
        // zero quaternion: identity rotation
        maj[r] = (gsr_pkg::axis_t'(r) == sd.first) ? gsr_pkg::ONE_Q14 : 16'sd0;
        mnr[r] = (gsr_pkg::axis_t'(r) == sd.second) ? gsr_pkg::ONE_Q14 : 16'sd0;
      end else begin
        maj[r] = rv[r];
        mnr[r] = rv[r+3];
      end
    end
    rect_next.major_axis_x  = maj[0];
    rect_next.major_axis_y  = maj[1];
    rect_next.major_axis_z  = maj[2];
    rect_next.minor_axis_x  = mnr[0];
    rect_next.minor_axis_y  = mnr[1];
    rect_next.minor_axis_z  = mnr[2];
    rect_next.rect_width    = ex_size[0];
    rect_next.rect_height   = ex_size[1];
    rect_next.rect_radius   = 32'((33'(ex_size[0]) + 33'(ex_size[1])) >> 2);
    rect_next.red_out       = sd.red;
    rect_next.green_out     = sd.green;
    rect_next.blue_out      = sd.blue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ex_vld;
    end
    rect <= rect_next;
  end

  `GSR_ASSERT_IMPL(a_fixed_latency, done, $past(start && !busy, gsr_pkg::PIPE_LAT), "stray result")
  `GSR_ASSERT_IMPL(a_width_ge_height, done, rect.rect_width >= rect.rect_height, "bad height")
  `GSR_ASSERT_ALWAYS(a_radius_bound, !done || (rect.rect_radius <= rect.rect_width), "bad radius")

endmodule
